// ----- rtl/bgba_pkg.sv -----
// Package for the block group bitmap allocator.
// Request/response transaction types, status and command codes, register indexes.
// No dependencies.
`default_nettype none

package bgba_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_INUSE = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] blk_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] granted_block;
        logic [12:0] free_total;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/block_group_bitmap_allocator.sv -----
// Block group bitmap allocator, first fit, with per-group used counters.
// Depends on bgba_pkg (transaction types, codes, register indexes).
// Bitmap lives in one synchronous RAM of 32-bit words with a registered read port.
//
//  channel   | signals                          | handshake
//  ----------+----------------------------------+------------------------------------
//  request   | start, req (cmd, blk_addr)       | taken at edge with start & !busy
//  response  | done, rsp (status, granted, free)| done high one cycle, always taken
//  config    | cfg_we, cfg_index, cfg_wdata     | written at edge with cfg_we high
//
// After reset busy stays high while the RAM is swept to zero: WORDS words (128 at default sizes).
// Allocate skips full groups, scans the first open group word by word, then sums the used
// counts of groups in use; with no room it sums after the walk. Free checks the range and
// sums if out of it, else finds the group by subtraction, reads the word, clears the bit if
// set and sums. Next transaction can be taken while done is high; the receiver cannot stall.
`default_nettype none

module block_group_bitmap_allocator #(
    parameter int GROUPS     = 8,
    parameter int GROUP_SIZE = 512
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire bgba_pkg::req_t                 req,
    output logic                                busy,
    output logic                                done,
    output bgba_pkg::rsp_t                      rsp,
    input  wire                                 cfg_we,
    input  wire [bgba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [bgba_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int TOTAL = GROUPS * GROUP_SIZE;
    localparam int WORDS = (TOTAL + 31) / 32;
    localparam int IDXW  = $clog2(TOTAL + 1);
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GCW   = $clog2(GROUPS + 1);
    localparam int GIW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNTW  = $clog2(GROUP_SIZE + 1);

    // controller states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_AFIND  = 4'd2;  // skip full groups, open a group or report full
    localparam logic [3:0] S_ASCAN  = 4'd3;  // examine one bitmap word per cycle
    localparam logic [3:0] S_FRANGE = 4'd4;
    localparam logic [3:0] S_FDIV   = 4'd5;  // block index -> group number
    localparam logic [3:0] S_FTEST  = 4'd6;
    localparam logic [3:0] S_SUM    = 4'd7;  // add up used counts of groups in use

    // ---------------- configuration ----------------
    logic [3:0]  groups_in_use_reg;
    logic [15:0] first_data_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_in_use_reg    <= 4'd8;
            first_data_block_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgba_pkg::REG_GROUPS_IN_USE:    groups_in_use_reg    <= cfg_wdata[3:0];
                bgba_pkg::REG_FIRST_DATA_BLOCK: first_data_block_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // groups actually managed: the register clamped to GROUPS
    logic [GCW-1:0] n_groups;
    assign n_groups = ({28'd0, groups_in_use_reg} > 32'(GROUPS)) ? GCW'(GROUPS)
                                                                 : GCW'(groups_in_use_reg);

    // ---------------- state ----------------
    logic [3:0]      state_reg, state_next;
    logic [WAW-1:0]  clr_reg, clr_next;
    logic [GCW-1:0]  g_reg, g_next;
    logic [IDXW-1:0] limit_reg, limit_next;   // n_groups * GROUP_SIZE
    logic [IDXW-1:0] acc_reg, acc_next;       // used-count sum
    logic [IDXW-1:0] rem_reg, rem_next;       // remainder during group lookup
    logic [IDXW-1:0] idx_reg, idx_next;       // bitmap index of the block to free
    logic [31:0]     off_reg, off_next;
    logic            below_reg, below_next;
    logic [WAW-1:0]  w_reg, w_next;
    logic [WAW-1:0]  start_w_reg, start_w_next;
    logic [WAW-1:0]  end_w_reg, end_w_next;
    logic [4:0]      lo_reg, lo_next;
    logic [4:0]      hi_reg, hi_next;
    logic [1:0]      status_reg, status_next;
    logic [16:0]     granted_reg, granted_next;
    logic            done_reg, done_next;
    bgba_pkg::rsp_t  rsp_reg, rsp_next;

    logic [CNTW-1:0] cnt_reg [GROUPS];
    logic            cnt_inc, cnt_dec;

    // ---------------- bitmap RAM ----------------
    logic [31:0]    mem [WORDS];
    logic           mem_we, mem_re;
    logic [WAW-1:0] mem_waddr, mem_raddr;
    logic [31:0]    mem_wdata;
    logic [31:0]    rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // ---------------- word scan helpers ----------------
    logic [GIW-1:0]  gi;
    logic [CNTW-1:0] cnt_cur;
    logic [IDXW-1:0] gbase, gend;
    logic [31:0]     scan_mask, cand;
    logic            found;
    logic [4:0]      pos;
    logic [IDXW-1:0] grant_idx;

    assign gi      = g_reg[GIW-1:0];
    assign cnt_cur = cnt_reg[gi];
    assign gbase   = IDXW'(32'(g_reg) * 32'(GROUP_SIZE));
    assign gend    = gbase + IDXW'(GROUP_SIZE - 1);

    // groups need not align to words: trim bits outside the group at both ends
    assign scan_mask = ((w_reg == start_w_reg) ? (32'hFFFF_FFFF << lo_reg) : 32'hFFFF_FFFF)
                     & ((w_reg == end_w_reg) ? (32'hFFFF_FFFF >> (5'd31 - hi_reg))
                                             : 32'hFFFF_FFFF);
    assign cand = ~rdata_reg & scan_mask;

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = 1'b1;
                pos   = 5'(i);
            end
        end
    end

    assign grant_idx = IDXW'({w_reg, pos});

    // ---------------- controller ----------------
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        g_next       = g_reg;
        limit_next   = limit_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        below_next   = below_reg;
        w_next       = w_reg;
        start_w_next = start_w_reg;
        end_w_next   = end_w_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        cnt_inc      = 1'b0;
        cnt_dec      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = w_reg;
        mem_wdata    = rdata_reg;
        mem_re       = 1'b0;
        mem_raddr    = w_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == WAW'(WORDS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    limit_next = IDXW'(32'(n_groups) * 32'(GROUP_SIZE));
                    g_next     = '0;
                    if (req.cmd == bgba_pkg::CMD_ALLOC)
                    begin
                        granted_next = '0;
                        state_next   = S_AFIND;
                    end
                    else
                    begin
                        granted_next = req.blk_addr[16:0];
                        below_next   = req.blk_addr < {16'd0, first_data_block_reg};
                        off_next     = req.blk_addr - {16'd0, first_data_block_reg};
                        state_next   = S_FRANGE;
                    end
                end
            end

            S_AFIND:
            begin
                if (g_reg >= n_groups)
                begin
                    status_next  = bgba_pkg::ST_FULL;
                    granted_next = '0;
                    g_next       = '0;
                    acc_next     = '0;
                    state_next   = S_SUM;
                end
                else if (cnt_cur >= CNTW'(GROUP_SIZE))
                begin
                    g_next = g_reg + 1'b1;
                end
                else
                begin
                    start_w_next = WAW'(gbase >> 5);
                    end_w_next   = WAW'(gend >> 5);
                    w_next       = WAW'(gbase >> 5);
                    lo_next      = gbase[4:0];
                    hi_next      = gend[4:0];
                    mem_re       = 1'b1;
                    mem_raddr    = WAW'(gbase >> 5);
                    state_next   = S_ASCAN;
                end
            end

            S_ASCAN:
            begin
                if (found)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = w_reg;
                    mem_wdata    = rdata_reg | (32'd1 << pos);
                    cnt_inc      = 1'b1;
                    status_next  = bgba_pkg::ST_OK;
                    granted_next = 17'({16'd0, first_data_block_reg} + 32'(grant_idx));
                    g_next       = '0;
                    acc_next     = '0;
                    state_next   = S_SUM;
                end
                else if (w_reg == end_w_reg)
                begin
                    // counters keep this from happening; move on to be safe
                    g_next     = g_reg + 1'b1;
                    state_next = S_AFIND;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = w_reg + 1'b1;
                end
            end

            S_FRANGE:
            begin
                if (below_reg || (off_reg >= 32'(limit_reg)))
                begin
                    status_next = bgba_pkg::ST_RANGE;
                    g_next      = '0;
                    acc_next    = '0;
                    state_next  = S_SUM;
                end
                else
                begin
                    rem_next   = IDXW'(off_reg);
                    idx_next   = IDXW'(off_reg);
                    g_next     = '0;
                    state_next = S_FDIV;
                end
            end

            S_FDIV:
            begin
                if ({1'b0, rem_reg} >= (IDXW + 1)'(GROUP_SIZE))
                begin
                    rem_next = rem_reg - IDXW'(GROUP_SIZE);
                    g_next   = g_reg + 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = WAW'(idx_reg >> 5);
                    state_next = S_FTEST;
                end
            end

            S_FTEST:
            begin
                if (!rdata_reg[idx_reg[4:0]])
                begin
                    status_next = bgba_pkg::ST_NOT_INUSE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = WAW'(idx_reg >> 5);
                    mem_wdata   = rdata_reg & ~(32'd1 << idx_reg[4:0]);
                    cnt_dec     = (cnt_cur != '0);
                    status_next = bgba_pkg::ST_OK;
                end
                g_next     = '0;
                acc_next   = '0;
                state_next = S_SUM;
            end

            S_SUM:
            begin
                if (g_reg == n_groups)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.granted_block = granted_reg;
                    rsp_next.free_total    = 13'(limit_reg - acc_reg);
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    acc_next = acc_reg + IDXW'(cnt_cur);
                    g_next   = g_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            g_reg     <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < GROUPS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            g_reg     <= g_next;
            done_reg  <= done_next;
            if (cnt_inc)
                cnt_reg[gi] <= cnt_cur + 1'b1;
            else if (cnt_dec)
                cnt_reg[gi] <= cnt_cur - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg   <= limit_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        below_reg   <= below_next;
        w_reg       <= w_next;
        start_w_reg <= start_w_next;
        end_w_reg   <= end_w_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
